// ===== rtl/vbrs_pkg.sv =====
// shared widths, register indexes and reset values of the rotation sampler
`default_nettype none
package vbrs_pkg;

  localparam int unsigned SIDE_DEF  = 64;
  localparam int unsigned CFG_W     = 54;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned COEF_W    = 18;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned VOX_W     = 16;
  localparam int unsigned BOUND_W   = 24;
  localparam int unsigned PROD_W    = POS_W + COEF_W;
  localparam int unsigned B_W       = PROD_W + 2;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned XL_W      = 34;
  localparam int unsigned YL_W      = 52;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0  = 3'd0,
    CFG_ROW1  = 3'd1,
    CFG_ROW2  = 3'd2,
    CFG_MODE  = 3'd3,
    CFG_LOWER = 3'd4,
    CFG_UPPER = 3'd5
  } cfg_idx_e;

  localparam logic ACT_LOAD     = 1'b0;
  localparam logic ACT_SAMPLE   = 1'b1;
  localparam logic MODE_NEAREST = 1'b0;

  localparam logic [CFG_W-1:0]   ROW0_RST  = 54'd65536;
  localparam logic [CFG_W-1:0]   ROW1_RST  = 54'd17179869184;
  localparam logic [CFG_W-1:0]   ROW2_RST  = 54'd4503599627370496;
  localparam logic               MODE_RST  = 1'b1;
  localparam logic [BOUND_W-1:0] LOWER_RST = 24'd14737632;
  localparam logic [BOUND_W-1:0] UPPER_RST = 24'd2039583;

  localparam logic signed [VOX_W-1:0] ONE_Q4  = 16'sd16;
  localparam logic signed [VOX_W-1:0] VOX_MAX = 16'sd32767;
  localparam logic signed [VOX_W-1:0] VOX_MIN = -16'sd32768;

endpackage
`default_nettype wire

// ===== rtl/vbrs_in_if.sv =====
// input channel: load or sample beat
`default_nettype none
interface vbrs_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  action;
  logic signed [vbrs_pkg::POS_W-1:0]     pos_x;
  logic signed [vbrs_pkg::POS_W-1:0]     pos_y;
  logic signed [vbrs_pkg::POS_W-1:0]     pos_z;
  logic signed [vbrs_pkg::VOX_W-1:0]     voxel_in;

  modport source (output valid, action, pos_x, pos_y, pos_z, voxel_in, input ready);
  modport sink   (input valid, action, pos_x, pos_y, pos_z, voxel_in, output ready);
endinterface
`default_nettype wire

// ===== rtl/vbrs_out_if.sv =====
// output channel: resampled voxel beat
`default_nettype none
interface vbrs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [vbrs_pkg::VOX_W-1:0] voxel_out;
  logic                              outside;

  modport source (output valid, voxel_out, outside, input ready);
  modport sink   (input valid, voxel_out, outside, output ready);
endinterface
`default_nettype wire

// ===== rtl/vbrs_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none
module vbrs_ram #(
  parameter int unsigned WIDTH = vbrs_pkg::VOX_W,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/volume_backward_rotation_sampler.sv =====
// a sample beat is registered at each of stages a to f before it shows at the output
// throughput: one beat per cycle, load or sample, while the sink does not stall the six-stage pipeline
// eight parity banks serve the eight corner reads of one sample in one cycle
// the whole pipeline holds while a finished result waits for its sink
// reset clears config to identity, trilinear, bounds -32..31; volume is not cleared
`default_nettype none
module volume_backward_rotation_sampler #(
  parameter int unsigned SIDE = vbrs_pkg::SIDE_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [vbrs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [vbrs_pkg::CFG_W-1:0]         cfg_data_i,
  vbrs_in_if.sink                                 in_i,
  vbrs_out_if.source                              out_o
);

  localparam int unsigned CW     = $clog2(SIDE);
  localparam int unsigned HALF   = SIDE / 2;
  localparam int unsigned BDEPTH = HALF * HALF * HALF;
  localparam int unsigned BAW    = $clog2(BDEPTH);
  localparam int unsigned PW     = vbrs_pkg::POS_W;
  localparam int unsigned VW     = vbrs_pkg::VOX_W;
  localparam int unsigned BW     = vbrs_pkg::B_W;
  localparam int unsigned PRW    = vbrs_pkg::PROD_W;
  localparam int unsigned FW     = vbrs_pkg::FRAC_W;
  localparam int unsigned XW     = vbrs_pkg::XL_W;
  localparam int unsigned YW     = vbrs_pkg::YL_W;

  // config registers
  logic [vbrs_pkg::CFG_W-1:0]   row_q [3];
  logic                         mode_q;
  logic [vbrs_pkg::BOUND_W-1:0] lower_q;
  logic [vbrs_pkg::BOUND_W-1:0] upper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= vbrs_pkg::ROW0_RST;
      row_q[1] <= vbrs_pkg::ROW1_RST;
      row_q[2] <= vbrs_pkg::ROW2_RST;
      mode_q   <= vbrs_pkg::MODE_RST;
      lower_q  <= vbrs_pkg::LOWER_RST;
      upper_q  <= vbrs_pkg::UPPER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vbrs_pkg::CFG_ROW0:  row_q[0] <= cfg_data_i;
        vbrs_pkg::CFG_ROW1:  row_q[1] <= cfg_data_i;
        vbrs_pkg::CFG_ROW2:  row_q[2] <= cfg_data_i;
        vbrs_pkg::CFG_MODE:  mode_q   <= cfg_data_i[0];
        vbrs_pkg::CFG_LOWER: lower_q  <= cfg_data_i[vbrs_pkg::BOUND_W-1:0];
        vbrs_pkg::CFG_UPPER: upper_q  <= cfg_data_i[vbrs_pkg::BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  logic nearest;
  assign nearest = (mode_q == vbrs_pkg::MODE_NEAREST);

  // coordinate wrap table
  logic [CW-1:0] wrap_lut [256];
  for (genvar g = 0; g < 256; g++) begin : g_wrap
    localparam int SV = (g < 128) ? g : g - 256;
    localparam int WV = ((SV % int'(SIDE)) + int'(SIDE)) % int'(SIDE);
    assign wrap_lut[g] = CW'(WV);
  end

  // handshake
  logic en;
  logic acc;
  logic out_vld_q;
  assign en       = !out_vld_q || out_o.ready;
  assign in_i.ready = en;
  assign acc      = in_i.valid && en;

  // stage a: products
  logic signed [PW-1:0]  p_in [3];
  logic signed [vbrs_pkg::COEF_W-1:0] coef [3][3];
  logic signed [PRW-1:0] prod_d [3][3];
  logic                  vld_a_q, act_a_q;
  logic signed [PW-1:0]  p_a_q [3];
  logic signed [VW-1:0]  vin_a_q;
  logic signed [PRW-1:0] prod_a_q [3][3];

  always_comb begin
    p_in[0] = in_i.pos_x;
    p_in[1] = in_i.pos_y;
    p_in[2] = in_i.pos_z;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        coef[i][k]   = signed'(row_q[i][vbrs_pkg::COEF_W*k +: vbrs_pkg::COEF_W]);
        prod_d[i][k] = PRW'(p_in[k]) * PRW'(coef[i][k]);
      end
    end
  end

  // stage b: back-rotated point
  logic signed [BW-1:0] b_d [3];
  logic                 vld_b_q, act_b_q;
  logic signed [PW-1:0] p_b_q [3];
  logic signed [VW-1:0] vin_b_q;
  logic signed [BW-1:0] b_b_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b_d[i] = BW'(prod_a_q[i][0]) + BW'(prod_a_q[i][1]) + BW'(prod_a_q[i][2]);
    end
  end

  // stage c: bounds, corner index, bank access
  logic signed [PW-1:0] lo [3];
  logic signed [PW-1:0] hi [3];
  logic signed [BW-1:0] lo_s [3];
  logic signed [BW-1:0] hi_s [3];
  logic signed [BW:0]   bx [3];
  logic signed [BW:0]   mag [3];
  logic signed [BW:0]   rnd [3];
  logic signed [BW:0]   rsg [3];
  logic [PW-1:0]        base [3];
  logic [PW-1:0]        upc [3];
  logic [FW-1:0]        frac_d [3];
  logic [CW-1:0]        w0 [3];
  logic [CW-1:0]        w1 [3];
  logic [CW-1:0]        wl [3];
  logic                 out_d;
  logic [2:0]           wbank;
  logic [BAW-1:0]       waddr;
  logic [BAW-1:0]       raddr [8];
  logic [CW-1:0]        ax [8][3];
  logic [VW-1:0]        rdata [8];

  always_comb begin
    out_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      lo[i]   = signed'(lower_q[PW*i +: PW]);
      hi[i]   = signed'(upper_q[PW*i +: PW]);
      lo_s[i] = BW'(signed'({lo[i], 16'h0000}));
      hi_s[i] = BW'(signed'({hi[i], 16'h0000}));
      if (b_b_q[i] <= lo_s[i] || b_b_q[i] >= hi_s[i]) begin
        out_d = 1'b1;
      end
      bx[i]  = (BW+1)'(b_b_q[i]);
      mag[i] = b_b_q[i][BW-1] ? -bx[i] : bx[i];
      rnd[i] = (mag[i] + (BW+1)'(32768)) >>> 16;
      rsg[i] = b_b_q[i][BW-1] ? -rnd[i] : rnd[i];
      base[i]   = nearest ? rsg[i][PW-1:0] : b_b_q[i][FW +: PW];
      upc[i]    = base[i] + PW'(1);
      frac_d[i] = nearest ? '0 : b_b_q[i][FW-1:0];
      w0[i] = wrap_lut[base[i]];
      w1[i] = wrap_lut[upc[i]];
      wl[i] = wrap_lut[unsigned'(p_b_q[i])];
    end
    wbank = {wl[2][0], wl[1][0], wl[0][0]};
    waddr = BAW'(wl[2][CW-1:1]) * BAW'(HALF * HALF) + BAW'(wl[1][CW-1:1]) * BAW'(HALF)
          + BAW'(wl[0][CW-1:1]);
  end

  for (genvar j = 0; j < 8; j++) begin : g_bank
    for (genvar i = 0; i < 3; i++) begin : g_axis
      localparam logic JB = 1'((j >> i) & 1);
      assign ax[j][i] = (w0[i][0] == JB) ? w0[i] : w1[i];
    end
    assign raddr[j] = BAW'(ax[j][2][CW-1:1]) * BAW'(HALF * HALF)
                    + BAW'(ax[j][1][CW-1:1]) * BAW'(HALF) + BAW'(ax[j][0][CW-1:1]);

    vbrs_ram #(
      .WIDTH (VW),
      .DEPTH (BDEPTH)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (en && vld_b_q && (act_b_q == vbrs_pkg::ACT_LOAD) && (wbank == 3'(j))),
      .waddr_i (waddr),
      .wdata_i (vin_b_q),
      .re_i    (en),
      .raddr_i (raddr[j]),
      .rdata_o (rdata[j])
    );
  end

  logic          vld_c_q, act_c_q, out_c_q, near_c_q;
  logic [FW-1:0] fr_c_q [3];
  logic [2:0]    par_c_q;

  // stage d: blend along x
  logic signed [VW-1:0] cv [8];
  logic signed [VW:0]   dx [4];
  logic signed [XW-1:0] xl_d [4];
  logic                 vld_d_q, act_d_q, out_d_q;
  logic [FW-1:0]        fy_d_q, fz_d_q;
  logic signed [XW-1:0] xl_q [4];

  for (genvar cc = 0; cc < 8; cc++) begin : g_corner
    logic [2:0] sel;
    assign sel    = 3'(cc) ^ par_c_q;
    assign cv[cc] = (near_c_q && (cc != 0)) ? '0 : signed'(rdata[sel]);
  end

  always_comb begin
    for (int q = 0; q < 4; q++) begin
      dx[q]   = (VW+1)'(cv[2*q+1]) - (VW+1)'(cv[2*q]);
      xl_d[q] = (XW'(cv[2*q]) <<< 16) + XW'(dx[q]) * XW'(signed'({1'b0, fr_c_q[0]}));
    end
  end

  // stage e: blend along y
  logic signed [YW-1:0] dy [2];
  logic signed [YW-1:0] yl_s [2];
  logic signed [XW-1:0] yl_d [2];
  logic                 vld_e_q, act_e_q, out_e_q;
  logic [FW-1:0]        fz_e_q;
  logic signed [XW-1:0] yl_q [2];

  always_comb begin
    for (int q = 0; q < 2; q++) begin
      dy[q]   = YW'(xl_q[2*q+1]) - YW'(xl_q[2*q]);
      yl_s[q] = (YW'(xl_q[2*q]) <<< 16) + dy[q] * YW'(signed'({1'b0, fy_d_q}))
              + YW'(32768);
      yl_d[q] = XW'(yl_s[q] >>> 16);
    end
  end

  // stage f: blend along z, saturate
  logic signed [YW-1:0] dz;
  logic signed [YW-1:0] zl_s;
  logic signed [19:0]   zv;
  logic signed [VW-1:0] vox_d;
  logic signed [VW-1:0] vox_q;
  logic                 outside_q;

  always_comb begin
    dz   = YW'(yl_q[1]) - YW'(yl_q[0]);
    zl_s = (YW'(yl_q[0]) <<< 16) + dz * YW'(signed'({1'b0, fz_e_q}))
         + YW'(32768);
    zv   = 20'(zl_s >>> 32);
    if (out_e_q) begin
      vox_d = vbrs_pkg::ONE_Q4;
    end else if (zv > 20'(vbrs_pkg::VOX_MAX)) begin
      vox_d = vbrs_pkg::VOX_MAX;
    end else if (zv < 20'(vbrs_pkg::VOX_MIN)) begin
      vox_d = vbrs_pkg::VOX_MIN;
    end else begin
      vox_d = zv[VW-1:0];
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q   <= 1'b0;
      vld_b_q   <= 1'b0;
      vld_c_q   <= 1'b0;
      vld_d_q   <= 1'b0;
      vld_e_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_a_q   <= acc;
      vld_b_q   <= vld_a_q;
      vld_c_q   <= vld_b_q;
      vld_d_q   <= vld_c_q;
      vld_e_q   <= vld_d_q;
      out_vld_q <= vld_e_q && (act_e_q == vbrs_pkg::ACT_SAMPLE);
    end
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    if (en) begin
      act_a_q  <= in_i.action;
      p_a_q    <= p_in;
      vin_a_q  <= in_i.voxel_in;
      prod_a_q <= prod_d;

      act_b_q  <= act_a_q;
      p_b_q    <= p_a_q;
      vin_b_q  <= vin_a_q;
      b_b_q    <= b_d;

      act_c_q  <= act_b_q;
      out_c_q  <= out_d;
      near_c_q <= nearest;
      fr_c_q   <= frac_d;
      par_c_q  <= {w0[2][0], w0[1][0], w0[0][0]};

      act_d_q  <= act_c_q;
      out_d_q  <= out_c_q;
      fy_d_q   <= fr_c_q[1];
      fz_d_q   <= fr_c_q[2];
      xl_q     <= xl_d;

      act_e_q  <= act_d_q;
      out_e_q  <= out_d_q;
      fz_e_q   <= fz_d_q;
      yl_q     <= yl_d;

      vox_q     <= vox_d;
      outside_q <= out_e_q;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.voxel_out = vox_q;
  assign out_o.outside   = outside_q;

endmodule
`default_nettype wire

// ===== tb/sv/vbrs_checker.sv =====
// checker of the rotation sampler: mirrors config and volume, predicts and compares beats
`default_nettype none
module vbrs_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [vbrs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [vbrs_pkg::CFG_W-1:0]     cfg_data_i,
  vbrs_in_if                                  in_mon,
  vbrs_out_if                                 out_mon,
  output int                                  errors_o,
  output int                                  pending_o
);
  import vbrs_pkg::*;

  typedef struct packed {
    logic signed [VOX_W-1:0] voxel;
    logic                    outside;
  } sample_res_t;

  logic [CFG_W-1:0]        row_q [3];
  logic                    mode_q;
  logic [BOUND_W-1:0]      lower_q;
  logic [BOUND_W-1:0]      upper_q;
  logic signed [VOX_W-1:0] volume [0:262143];
  sample_res_t             sample_q [$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  function automatic int vox_addr(longint x, longint y, longint z);
    return ((int'(z) & 63) * 64 + (int'(y) & 63)) * 64 + (int'(x) & 63);
  endfunction

  function automatic longint vox_rd(longint x, longint y, longint z);
    return longint'(volume[vox_addr(x, y, z)]);
  endfunction

  function automatic longint blend(longint a, longint b, longint f);
    return a * (65536 - f) + b * f;
  endfunction

  function automatic sample_res_t resample(logic signed [POS_W-1:0] px,
                                           logic signed [POS_W-1:0] py,
                                           logic signed [POS_W-1:0] pz);
    longint p [3];
    longint b [3];
    longint lo [3];
    longint hi [3];
    longint fl [3];
    longint fr [3];
    longint up [3];
    longint c00, c01, c10, c11, c0, c1v, val;
    logic out_flag;
    sample_res_t res;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    out_flag = 1'b0;
    for (int i = 0; i < 3; i++) begin
      b[i] = 0;
      for (int k = 0; k < 3; k++)
        b[i] += p[k] * longint'($signed(row_q[i][COEF_W*k +: COEF_W]));
      lo[i] = longint'($signed(lower_q[8*i +: 8]));
      hi[i] = longint'($signed(upper_q[8*i +: 8]));
      if (b[i] <= lo[i] * 65536 || b[i] >= hi[i] * 65536) out_flag = 1'b1;
    end
    if (out_flag) begin
      res.voxel   = ONE_Q4;
      res.outside = 1'b1;
      return res;
    end
    if (mode_q == MODE_NEAREST) begin
      for (int i = 0; i < 3; i++)
        fl[i] = (b[i] >= 0) ? ((b[i] + 32768) >>> 16) : -((-b[i] + 32768) >>> 16);
      val = vox_rd(fl[0], fl[1], fl[2]);
    end else begin
      for (int i = 0; i < 3; i++) begin
        fl[i] = b[i] >>> 16;
        fr[i] = b[i] - fl[i] * 65536;
        up[i] = (fl[i] + 1 > hi[i]) ? fl[i] : fl[i] + 1;
      end
      c00 = blend(vox_rd(fl[0], fl[1], fl[2]), vox_rd(up[0], fl[1], fl[2]), fr[0]);
      c01 = blend(vox_rd(fl[0], fl[1], up[2]), vox_rd(up[0], fl[1], up[2]), fr[0]);
      c10 = blend(vox_rd(fl[0], up[1], fl[2]), vox_rd(up[0], up[1], fl[2]), fr[0]);
      c11 = blend(vox_rd(fl[0], up[1], up[2]), vox_rd(up[0], up[1], up[2]), fr[0]);
      c0  = (blend(c00, c10, fr[1]) + 32768) >>> 16;
      c1v = (blend(c01, c11, fr[1]) + 32768) >>> 16;
      val = (blend(c0, c1v, fr[2]) + 32768) >>> 32;
    end
    if (val > 32767) val = 32767;
    if (val < -32768) val = -32768;
    res.voxel   = VOX_W'(val);
    res.outside = 1'b0;
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sample_res_t want;
    if (!rst_ni) begin
      row_q[0] <= ROW0_RST;
      row_q[1] <= ROW1_RST;
      row_q[2] <= ROW2_RST;
      mode_q   <= MODE_RST;
      lower_q  <= LOWER_RST;
      upper_q  <= UPPER_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ROW0:  row_q[0] <= cfg_data_i;
          CFG_ROW1:  row_q[1] <= cfg_data_i;
          CFG_ROW2:  row_q[2] <= cfg_data_i;
          CFG_MODE:  mode_q   <= cfg_data_i[0];
          CFG_LOWER: lower_q  <= cfg_data_i[BOUND_W-1:0];
          CFG_UPPER: upper_q  <= cfg_data_i[BOUND_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (sample_q.size() == 0) begin
          report("unexpected beat", out_mon.voxel_out, 0);
        end else begin
          want = sample_q.pop_front();
          if (out_mon.voxel_out !== want.voxel)
            report("voxel_out", out_mon.voxel_out, want.voxel);
          if (out_mon.outside !== want.outside)
            report("outside", out_mon.outside, want.outside);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == ACT_LOAD)
          volume[vox_addr(in_mon.pos_x, in_mon.pos_y, in_mon.pos_z)] = in_mon.voxel_in;
        else
          sample_q.push_back(resample(in_mon.pos_x, in_mon.pos_y, in_mon.pos_z));
      end
      pending_o = sample_q.size();
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/tb_volume_backward_rotation_sampler.sv =====
// top of the rotation sampler testbench: clock, reset, stimulus and verdict
`default_nettype none
module tb_volume_backward_rotation_sampler;
  import vbrs_pkg::*;

  localparam int LIMIT = 300000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  int                   errors;
  int                   pending;
  int                   cycles;
  bit                   calm;
  bit                   written [0:262143];
  int                   lo_c, hi_c;

  vbrs_in_if  in_bus ();
  vbrs_out_if out_bus ();

  volume_backward_rotation_sampler dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  vbrs_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_bus.ready <= calm || ($urandom_range(99) >= 37);
  end

  function automatic int wrap_addr(int x, int y, int z);
    return ((z & 63) * 64 + (y & 63)) * 64 + (x & 63);
  endfunction

  function automatic logic [CFG_W-1:0] pack_row(int c0, int c1, int c2);
    return {COEF_W'(c2), COEF_W'(c1), COEF_W'(c0)};
  endfunction

  function automatic logic [BOUND_W-1:0] pack_corner(int c);
    return {8'(c), 8'(c), 8'(c)};
  endfunction

  function automatic int clamp8(int v);
    return (v < -128) ? -128 : (v > 127) ? 127 : v;
  endfunction

  task automatic send(logic act, int x, int y, int z, int v);
    bit taken;
    while (!calm && $urandom_range(99) < 37) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid    <= 1'b1;
    in_bus.action   <= act;
    in_bus.pos_x    <= POS_W'(x);
    in_bus.pos_y    <= POS_W'(y);
    in_bus.pos_z    <= POS_W'(z);
    in_bus.voxel_in <= VOX_W'(v);
    if (act == ACT_LOAD) written[wrap_addr(x, y, z)] = 1'b1;
    do begin
      @(negedge clk_i);
      taken = in_bus.ready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic drain();
    if (in_bus.valid) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  // all six registers; the bound cube is the same on every axis unless split
  task automatic configure(logic [CFG_W-1:0] r0, logic [CFG_W-1:0] r1,
                           logic [CFG_W-1:0] r2, logic mode,
                           logic [BOUND_W-1:0] lower, logic [BOUND_W-1:0] upper);
    drain();
    write_reg(CFG_ROW0, r0);
    write_reg(CFG_ROW1, r1);
    write_reg(CFG_ROW2, r2);
    write_reg(CFG_MODE, CFG_W'(mode));
    write_reg(CFG_LOWER, CFG_W'(lower));
    write_reg(CFG_UPPER, CFG_W'(upper));
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // every voxel an inside sample can read lies in lo..hi on each axis
  task automatic fill_cube(int lo, int hi);
    for (int z = lo; z <= hi; z++)
      for (int y = lo; y <= hi; y++)
        for (int x = lo; x <= hi; x++)
          if (!written[wrap_addr(x, y, z)])
            send(ACT_LOAD, x, y, z, int'($urandom_range(65535)));
  endtask

  task automatic cube_phase(logic [CFG_W-1:0] r0, logic [CFG_W-1:0] r1,
                            logic [CFG_W-1:0] r2, logic mode, int lo, int hi);
    configure(r0, r1, r2, mode, pack_corner(lo), pack_corner(hi));
    lo_c = lo;
    hi_c = hi;
    if (lo < hi) fill_cube(lo, hi);
  endtask

  task automatic near_sample();
    send(ACT_SAMPLE, clamp8($urandom_range(hi_c - lo_c + 4) + lo_c - 2),
         clamp8($urandom_range(hi_c - lo_c + 4) + lo_c - 2),
         clamp8($urandom_range(hi_c - lo_c + 4) + lo_c - 2), 0);
  endtask

  task automatic random_phase(int kind, int n);
    int lo, hi, s, perm, sg [3], coef [3][3];
    logic [CFG_W-1:0] r [3];
    logic mode;
    mode = 1'($urandom_range(1));
    case (kind)
      0: begin
        perm = $urandom_range(2);
        for (int i = 0; i < 3; i++) begin
          sg[i] = $urandom_range(1) ? 1 : -1;
          for (int k = 0; k < 3; k++)
            coef[i][k] = (k == (i + perm) % 3) ?
                         sg[i] * (65536 + int'($urandom_range(8191)) - 4096) :
                         int'($urandom_range(4095)) - 2048;
          r[i] = pack_row(coef[i][0], coef[i][1], coef[i][2]);
        end
        s  = $urandom_range(2, 1);
        lo = -s;
        hi = s;
      end
      1: begin
        for (int i = 0; i < 3; i++)
          r[i] = pack_row(int'($urandom_range(78643)) - 39321,
                          int'($urandom_range(78643)) - 39321,
                          int'($urandom_range(78643)) - 39321);
        lo = -int'($urandom_range(2, 1));
        hi = $urandom_range(2, 1);
      end
      2: begin
        for (int i = 0; i < 3; i++) r[i] = CFG_W'({$urandom, $urandom});
        lo = int'($urandom_range(240)) - 128;
        hi = clamp8(lo + int'($urandom_range(2, 1)));
      end
      default: begin
        for (int i = 0; i < 3; i++) r[i] = CFG_W'({$urandom, $urandom});
        lo = int'($urandom_range(255)) - 128;
        hi = clamp8(lo - int'($urandom_range(5)));
        if (hi < -128) hi = -128;
      end
    endcase
    cube_phase(r[0], r[1], r[2], mode, lo, hi);
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(3) == 0)
        send(ACT_LOAD, int'($urandom_range(255)) - 128, int'($urandom_range(255)) - 128,
             int'($urandom_range(255)) - 128, int'($urandom_range(65535)));
      else if (kind >= 2 && $urandom_range(1))
        send(ACT_SAMPLE, int'($urandom_range(255)) - 128, int'($urandom_range(255)) - 128,
             int'($urandom_range(255)) - 128, 0);
      else
        near_sample();
    end
  endtask

  initial begin
    logic [CFG_W-1:0] half, id0, id1, id2;
    cycles        = 0;
    calm          = 1'b0;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    in_bus.valid  = 1'b0;
    in_bus.action = ACT_LOAD;
    in_bus.pos_x  = '0;
    in_bus.pos_y  = '0;
    in_bus.pos_z  = '0;
    in_bus.voxel_in = '0;
    out_bus.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    id0 = pack_row(65536, 0, 0);
    id1 = pack_row(0, 65536, 0);
    id2 = pack_row(0, 0, 65536);
    // identity, trilinear, small cube; value extremes and the bound edges
    cube_phase(id0, id1, id2, 1'b1, -2, 2);
    send(ACT_LOAD, 0, 0, 0, 32767);
    send(ACT_LOAD, 1, 0, 0, -32768);
    send(ACT_SAMPLE, 0, 0, 0, 0);
    send(ACT_SAMPLE, 1, 0, 0, 0);
    send(ACT_SAMPLE, 1, -1, 1, 0);
    send(ACT_SAMPLE, 2, 0, 0, 0);
    send(ACT_SAMPLE, 0, -2, 0, 0);
    send(ACT_SAMPLE, -128, -128, -128, 0);
    send(ACT_SAMPLE, 127, 127, 127, 0);
    send(ACT_SAMPLE, 0, 0, 127, 0);
    // half scale gives fractions: blend, then nearest with ties away from zero
    half = pack_row(32768, 0, 0);
    cube_phase(half, pack_row(0, 32768, 0), pack_row(0, 0, 32768), 1'b1, -2, 2);
    send(ACT_SAMPLE, 1, 0, 0, 0);
    send(ACT_SAMPLE, -1, 3, -5, 0);
    send(ACT_SAMPLE, 5, 5, 5, 0);
    cube_phase(half, pack_row(0, 32768, 0), pack_row(0, 0, 32768), MODE_NEAREST, -2, 2);
    send(ACT_SAMPLE, 1, 0, 0, 0);
    send(ACT_SAMPLE, -1, -1, -1, 0);
    send(ACT_SAMPLE, 3, -3, 1, 0);
    // coefficient extremes and an empty cube
    cube_phase(pack_row(131071, -131072, 131071), pack_row(-131072, 131071, -131072),
               {CFG_W{1'b1}}, 1'b1, 5, 5);
    send(ACT_SAMPLE, 1, 1, 1, 0);
    send(ACT_SAMPLE, -128, 127, 0, 0);
    // bound extremes with identity
    cube_phase(id0, id1, id2, 1'b0, -128, -126);
    for (int j = 0; j < 10; j++) near_sample();
    cube_phase(id0, id1, id2, 1'b1, 125, 127);
    for (int j = 0; j < 10; j++) near_sample();

    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 5);
      random_phase(ph % 4, 22);
    end
    calm = 1'b0;

    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
